// ===== rtl/core/prte_pkg.sv =====
// shared types, codes and helpers of the priority rule table state machine engine
// used by prte_rule_mem, prte_sel and priority_rule_table_fsm_engine_unit
package prte_pkg;

  localparam int MAX_RULES_DEF  = 32;
  localparam int NUM_CONDITIONS = 8;
  localparam int NUM_ACTIONS    = 8;

  localparam logic [5:0] NONE_FIRED  = 6'd32;
  localparam logic [7:0] ACTION_KEEP =
    (NUM_ACTIONS >= 8) ? 8'hFF : 8'((32'd1 << NUM_ACTIONS) - 32'd1);

  // operation codes
  localparam logic [1:0] OP_STEP    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_TERMINAL_MASK = 2'd0;
  localparam logic [1:0] CFG_RULE_COUNT    = 2'd1;
  localparam logic [1:0] CFG_START_STATE   = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] condition_lines;
    logic [4:0] rule_index;
    logic [3:0] rule_from;
    logic [3:0] rule_to;
    logic [7:0] rule_priority;
    logic       rule_has_condition;
    logic [2:0] rule_condition;
    logic       rule_timer_reset;
    logic [7:0] rule_actions;
  } in_word_t;

  typedef struct packed {
    logic        finished;
    logic        no_rule;
    logic [3:0]  state_now;
    logic [5:0]  fired_rule;
    logic [7:0]  action_mask;
    logic [31:0] tick_count;
  } out_word_t;

  typedef struct packed {
    logic [3:0] from_state;
    logic [3:0] to_state;
    logic [7:0] priority_val;
    logic       has_cond;
    logic [2:0] cond;
    logic       timer_reset;
    logic [7:0] actions;
  } rule_t;

  // winner handed from the selection unit to the sequencer
  typedef struct packed {
    logic       found;
    logic [3:0] to_state;
    logic       timer_reset;
    logic [7:0] actions;
  } pick_t;

  function automatic logic cond_true(input logic [7:0] lines, input logic [2:0] idx);
    logic ok;
    ok = (32'(idx) < NUM_CONDITIONS) && lines[idx];
    return ok;
  endfunction

endpackage

// ===== rtl/core/prte_rule_mem.sv =====
// rule table storage: one write port, one registered read port
// depends on prte_pkg for the rule entry type
module prte_rule_mem #(
  parameter int MAX_RULES = prte_pkg::MAX_RULES_DEF,
  parameter int AW        = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  prte_pkg::rule_t      wdata,
  input  logic [AW-1:0]        raddr,
  output prte_pkg::rule_t      rdata
);
  import prte_pkg::*;

  rule_t mem [MAX_RULES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/prte_sel.sv =====
// rule selection unit: compares one table entry per cycle against the running best
// and remembers the last default rule; depends on prte_pkg
module prte_sel #(
  parameter int MAX_RULES = prte_pkg::MAX_RULES_DEF,
  parameter int AW        = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  logic              eval_valid,
  input  logic [AW-1:0]     eval_idx,
  input  prte_pkg::rule_t   entry,
  input  logic [3:0]        cur_state,
  input  logic [7:0]        lines,
  output prte_pkg::pick_t   pick,
  output logic [AW-1:0]     pick_idx
);
  import prte_pkg::*;

  logic          best_found;
  logic [AW-1:0] best_idx;
  logic [7:0]    best_prio;
  rule_t         best_rule;
  logic          dflt_found;
  logic [AW-1:0] dflt_idx;
  rule_t         dflt_rule;

  logic match;
  logic take_best;
  logic take_dflt;

  always_comb begin
    match     = eval_valid && (entry.from_state == cur_state);
    take_dflt = match && !entry.has_cond;
    take_best = match && entry.has_cond && cond_true(lines, entry.cond) &&
                (!best_found || (entry.priority_val < best_prio));
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      best_found <= 1'b0;
      dflt_found <= 1'b0;
    end else begin
      if (take_best) begin
        best_found <= 1'b1;
      end
      if (take_dflt) begin
        dflt_found <= 1'b1;
      end
    end
    if (take_best) begin
      best_idx  <= eval_idx;
      best_prio <= entry.priority_val;
      best_rule <= entry;
    end
    if (take_dflt) begin
      dflt_idx  <= eval_idx;
      dflt_rule <= entry;
    end
  end

  always_comb begin
    if (best_found) begin
      pick.found       = 1'b1;
      pick.to_state    = best_rule.to_state;
      pick.timer_reset = best_rule.timer_reset;
      pick.actions     = best_rule.actions;
      pick_idx         = best_idx;
    end else begin
      pick.found       = dflt_found;
      pick.to_state    = dflt_rule.to_state;
      pick.timer_reset = dflt_rule.timer_reset;
      pick.actions     = dflt_rule.actions;
      pick_idx         = dflt_idx;
    end
  end

endmodule

// ===== rtl/core/priority_rule_table_fsm_engine_unit.sv =====
// step: accept, then one table read per rule entry in use, one drain, one decide and
// one output state; the output state waits while the previous word is not yet taken,
// and no new word is accepted meanwhile; the scan reads the table through its read port in order
// write, restart, no-op, terminal: straight to output; no entries in use: decide, output
// synchronous active-high reset clears state, tick counter, configuration registers and handshakes;
// the rule table is not cleared and must be written before use
module priority_rule_table_fsm_engine_unit #(
  parameter int MAX_RULES = prte_pkg::MAX_RULES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  prte_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output prte_pkg::out_word_t out_word
);
  import prte_pkg::*;

  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_FIN    = 5'b10000
  } seq_state_t;

  seq_state_t    state;
  logic [15:0]   terminal_mask;
  logic [5:0]    rule_count;
  logic [3:0]    start_state;
  logic [3:0]    cur_state;
  logic [31:0]   tick;
  logic [7:0]    lines;
  logic [AW-1:0] scan_idx;
  logic [AW-1:0] scan_last;
  logic          eval_valid;
  logic [AW-1:0] eval_idx;
  logic          res_finished;
  logic          res_no_rule;
  logic [5:0]    res_fired;
  logic [7:0]    res_actions;

  logic          accept;
  logic          mem_we;
  rule_t         wr_rule;
  rule_t         rd_rule;
  pick_t         pick;
  logic [AW-1:0] pick_idx;
  logic          fin_load;
  int            n_rules;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_load = (state == ST_FIN) && (!out_valid || out_ready);

  always_comb begin
    n_rules = (32'(rule_count) > MAX_RULES) ? MAX_RULES : 32'(rule_count);
    mem_we  = accept && (in_word.operation == OP_WRITE) &&
              (32'(in_word.rule_index) < MAX_RULES);
    wr_rule.from_state   = in_word.rule_from;
    wr_rule.to_state     = in_word.rule_to;
    wr_rule.priority_val = in_word.rule_priority;
    wr_rule.has_cond     = in_word.rule_has_condition;
    wr_rule.cond         = in_word.rule_condition;
    wr_rule.timer_reset  = in_word.rule_timer_reset;
    wr_rule.actions      = in_word.rule_actions & ACTION_KEEP;
  end

  prte_rule_mem #(
    .MAX_RULES (MAX_RULES),
    .AW        (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (in_word.rule_index[AW-1:0]),
    .wdata (wr_rule),
    .raddr (scan_idx),
    .rdata (rd_rule)
  );

  prte_sel #(
    .MAX_RULES (MAX_RULES),
    .AW        (AW)
  ) u_sel (
    .clk        (clk),
    .rst        (rst),
    .clr        (accept),
    .eval_valid (eval_valid),
    .eval_idx   (eval_idx),
    .entry      (rd_rule),
    .cur_state  (cur_state),
    .lines      (lines),
    .pick       (pick),
    .pick_idx   (pick_idx)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      terminal_mask <= '0;
      rule_count    <= '0;
      start_state   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TERMINAL_MASK: terminal_mask <= cfg_data;
        CFG_RULE_COUNT:    rule_count    <= cfg_data[5:0];
        CFG_START_STATE:   start_state   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur_state  <= '0;
      tick       <= '0;
      eval_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      eval_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            lines        <= in_word.condition_lines;
            res_finished <= 1'b0;
            res_no_rule  <= 1'b0;
            res_fired    <= NONE_FIRED;
            res_actions  <= '0;
            scan_idx     <= '0;
            scan_last    <= AW'(n_rules - 1);
            state        <= ST_FIN;
            case (in_word.operation)
              OP_STEP: begin
                if (tick != '1) begin
                  tick <= tick + 32'd1;
                end
                if (terminal_mask[cur_state]) begin
                  res_finished <= 1'b1;
                end else if (n_rules == 0) begin
                  state <= ST_DECIDE;
                end else begin
                  state <= ST_SCAN;
                end
              end
              OP_RESTART: begin
                cur_state <= start_state;
                tick      <= '0;
              end
              OP_WRITE, OP_NOP: ;
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          // registered read: the data lands in the cycle after the address
          eval_valid <= 1'b1;
          eval_idx   <= scan_idx;
          if (scan_idx == scan_last) begin
            state <= ST_DRAIN;
          end else begin
            scan_idx <= scan_idx + AW'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (pick.found) begin
            cur_state   <= pick.to_state;
            res_fired   <= 6'(pick_idx);
            res_actions <= pick.actions;
            if (pick.timer_reset) begin
              tick <= '0;
            end
          end else begin
            res_no_rule <= 1'b1;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_load) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_word.finished    <= res_finished;
      out_word.no_rule     <= res_no_rule;
      out_word.state_now   <= cur_state;
      out_word.fired_rule  <= res_fired;
      out_word.action_mask <= res_actions;
      out_word.tick_count  <= tick;
    end
  end

`ifndef SYNTHESIS
  a_eval_in_scan: assert property (@(posedge clk) disable iff (rst)
    eval_valid |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("table entry evaluated outside the scan");

  a_tick_saturates: assert property (@(posedge clk) disable iff (rst)
    (accept && in_word.operation == OP_STEP && tick == '1) |=> (tick == '1))
    else $error("tick counter wrapped");

  a_no_rule_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.no_rule) |->
      (out_word.fired_rule == NONE_FIRED && out_word.action_mask == '0 &&
       !out_word.finished))
    else $error("no-rule word carries a fired rule");
`endif

endmodule

// ===== verif/priority_rule_table_fsm_engine_unit_tb.sv =====
// testbench of the priority rule table state machine engine: a directed table, then
// random phases under several register settings, every word checked against a local model or a directed expected word
// depends on prte_pkg and priority_rule_table_fsm_engine_unit
module priority_rule_table_fsm_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prte_pkg::*;

  localparam int RANDOM_ITEMS  = 1550;
  localparam int PHASES        = 10;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_val;
    in_word_t    word;
    logic        typed;
    out_word_t   want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_word;

  // local copy of the engine state and registers
  rule_t      rule_shadow [MAX_RULES_DEF];
  bit [31:0]  entry_written = '0;
  bit [3:0]   cur_state = '0;
  bit [31:0]  ticks = '0;
  bit [15:0]  term_mask = '0;
  bit [5:0]   rule_cnt = '0;
  bit [3:0]   start_st = '0;

  out_word_t   pending_results[$];
  stim_row_t   directed_rows[$];
  out_word_t   oldest;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  priority_rule_table_fsm_engine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int live_entries();
    return (rule_cnt > MAX_RULES_DEF) ? MAX_RULES_DEF : int'(rule_cnt);
  endfunction

  function automatic out_word_t predict_engine(input in_word_t w);
    out_word_t r;
    int        best;
    int        dflt;
    int        i;
    r = '0;
    r.fired_rule = NONE_FIRED;
    case (w.operation)
      OP_WRITE: begin
        rule_shadow[w.rule_index].from_state   = w.rule_from;
        rule_shadow[w.rule_index].to_state     = w.rule_to;
        rule_shadow[w.rule_index].priority_val = w.rule_priority;
        rule_shadow[w.rule_index].has_cond     = w.rule_has_condition;
        rule_shadow[w.rule_index].cond         = w.rule_condition;
        rule_shadow[w.rule_index].timer_reset  = w.rule_timer_reset;
        rule_shadow[w.rule_index].actions      = w.rule_actions & ACTION_KEEP;
        entry_written[w.rule_index] = 1'b1;
      end
      OP_RESTART: begin
        cur_state = start_st;
        ticks = '0;
      end
      OP_STEP: begin
        if (ticks != 32'hFFFF_FFFF) ticks = ticks + 32'd1;
        if (term_mask[cur_state]) begin
          r.finished = 1'b1;
        end else begin
          best = -1;
          dflt = -1;
          for (i = 0; i < live_entries(); i++) begin
            if (rule_shadow[i].from_state == cur_state) begin
              if (!rule_shadow[i].has_cond) begin
                dflt = i;
              end else if (w.condition_lines[rule_shadow[i].cond]) begin
                // strict compare keeps the earlier entry on a tie
                if (best < 0) best = i;
                else if (rule_shadow[i].priority_val < rule_shadow[best].priority_val) best = i;
              end
            end
          end
          if (best < 0) best = dflt;
          if (best < 0) begin
            r.no_rule = 1'b1;
          end else begin
            if (rule_shadow[best].timer_reset) ticks = '0;
            r.action_mask = rule_shadow[best].actions;
            cur_state = rule_shadow[best].to_state;
            r.fired_rule = 6'(best);
          end
        end
      end
      default: ;
    endcase
    r.state_now = cur_state;
    r.tick_count = ticks;
    return r;
  endfunction

  function automatic in_word_t mk_word(input logic [1:0] op, input logic [7:0] lines,
                                       input logic [4:0] idx, input logic [3:0] from_s,
                                       input logic [3:0] to_s, input logic [7:0] prio,
                                       input logic hc, input logic [2:0] cond,
                                       input logic tr, input logic [7:0] act);
    in_word_t w;
    w.operation          = op;
    w.condition_lines    = lines;
    w.rule_index         = idx;
    w.rule_from          = from_s;
    w.rule_to            = to_s;
    w.rule_priority      = prio;
    w.rule_has_condition = hc;
    w.rule_condition     = cond;
    w.rule_timer_reset   = tr;
    w.rule_actions       = act;
    return w;
  endfunction

  function automatic out_word_t exp_word(input logic fin, input logic nr, input logic [3:0] st,
                                         input logic [5:0] fired, input logic [7:0] act,
                                         input logic [31:0] tick);
    out_word_t r;
    r.finished    = fin;
    r.no_rule     = nr;
    r.state_now   = st;
    r.fired_rule  = fired;
    r.action_mask = act;
    r.tick_count  = tick;
    return r;
  endfunction

  task automatic add_item(input in_word_t w, input logic typed, input out_word_t want);
    stim_row_t row;
    row = '0;
    row.word  = w;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [15:0] val);
    stim_row_t row;
    row = '0;
    row.is_cfg  = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    directed_rows.push_back(row);
  endtask

  function automatic in_word_t random_word(input bit [3:0] span);
    in_word_t    w;
    logic [63:0] raw;
    int          pick;
    int          n;
    int          i;
    raw = {$urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    pick = $urandom_range(99);
    n = live_entries();
    if (pick < 55) w.operation = OP_STEP;
    else if (pick < 78) w.operation = OP_WRITE;
    else if (pick < 90) w.operation = OP_RESTART;
    else w.operation = OP_NOP;
    if (w.operation == OP_WRITE) begin
      // keep rules inside the state range of this phase so steps find them
      w.rule_from = w.rule_from & span;
      w.rule_to = w.rule_to & span;
      if ($urandom_range(1) == 0) w.rule_priority = 8'($urandom_range(3));
      if (n > 0 && $urandom_range(9) < 7) w.rule_index = 5'($urandom_range(n - 1));
    end
    // a step may only scan entries that hold a written rule
    if (w.operation == OP_STEP) begin
      for (i = n - 1; i >= 0; i--) begin
        if (!entry_written[i]) begin
          w.operation = OP_WRITE;
          w.rule_index = 5'(i);
          w.rule_from = w.rule_from & span;
          w.rule_to = w.rule_to & span;
        end
      end
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
    out_word_t predicted;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    predicted = predict_engine(w);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TERMINAL_MASK: term_mask = val;
      CFG_RULE_COUNT:    rule_cnt = val[5:0];
      CFG_START_STATE:   start_st = val[3:0];
      default: ;
    endcase
  endtask

  // receiver: stretches of always-ready, coin-flip and mostly-stalled
  initial begin
    int mode;
    int len;
    out_ready <= 1'b0;
    forever begin
      mode = $urandom_range(2);
      len = $urandom_range(20, 200);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(1) == 0);
          default: out_ready <= ($urandom_range(7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("word with nothing pending: %h", out_word);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_word.finished !== oldest.finished) begin
          $error("finished: expected %0d, got %0d", oldest.finished, out_word.finished);
          mismatches++;
        end
        if (out_word.no_rule !== oldest.no_rule) begin
          $error("no_rule: expected %0d, got %0d", oldest.no_rule, out_word.no_rule);
          mismatches++;
        end
        if (out_word.state_now !== oldest.state_now) begin
          $error("state_now: expected %0d, got %0d", oldest.state_now, out_word.state_now);
          mismatches++;
        end
        if (out_word.fired_rule !== oldest.fired_rule) begin
          $error("fired_rule: expected %0d, got %0d", oldest.fired_rule, out_word.fired_rule);
          mismatches++;
        end
        if (out_word.action_mask !== oldest.action_mask) begin
          $error("action_mask: expected %h, got %h", oldest.action_mask, out_word.action_mask);
          mismatches++;
        end
        if (out_word.tick_count !== oldest.tick_count) begin
          $error("tick_count: expected %0d, got %0d", oldest.tick_count, out_word.tick_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    int          phase;
    int          k;
    int          per_phase;
    int          pause_at;
    int          burst_left;
    int          gap;
    bit          no_gaps;
    bit [3:0]    span;
    logic [15:0] tm;
    logic [15:0] rc;
    logic [15:0] ss;

    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst       <= 1'b1;

    // after reset: no rules in use, nothing terminal
    add_item(mk_word(OP_STEP, 8'h00, 5'd0, 4'd0, 4'd0, 8'd0, 1'b0, 3'd0, 1'b0, 8'h00),
             1'b1, exp_word(1'b0, 1'b1, 4'd0, NONE_FIRED, 8'h00, 32'd1));
    add_item(mk_word(OP_NOP, 8'hFF, 5'd31, 4'd15, 4'd15, 8'd255, 1'b1, 3'd7, 1'b1, 8'hFF),
             1'b1, exp_word(1'b0, 1'b0, 4'd0, NONE_FIRED, 8'h00, 32'd1));
    add_item(mk_word(OP_RESTART, 8'hFF, 5'd31, 4'd15, 4'd15, 8'd255, 1'b1, 3'd7, 1'b1, 8'hFF),
             1'b1, exp_word(1'b0, 1'b0, 4'd0, NONE_FIRED, 8'h00, 32'd0));
    add_item(mk_word(OP_WRITE, 8'h00, 5'd0, 4'd0, 4'd15, 8'd255, 1'b1, 3'd0, 1'b0, 8'hFF),
             1'b1, exp_word(1'b0, 1'b0, 4'd0, NONE_FIRED, 8'h00, 32'd0));
    add_item(mk_word(OP_WRITE, 8'h00, 5'd1, 4'd0, 4'd5, 8'd0, 1'b1, 3'd7, 1'b1, 8'h01),
             1'b1, exp_word(1'b0, 1'b0, 4'd0, NONE_FIRED, 8'h00, 32'd0));
    // default rule: its priority is ignored
    add_item(mk_word(OP_WRITE, 8'h00, 5'd2, 4'd0, 4'd3, 8'd255, 1'b0, 3'd7, 1'b0, 8'h80),
             1'b1, exp_word(1'b0, 1'b0, 4'd0, NONE_FIRED, 8'h00, 32'd0));
    add_item(mk_word(OP_WRITE, 8'h00, 5'd3, 4'd0, 4'd4, 8'd0, 1'b1, 3'd0, 1'b0, 8'h10),
             1'b1, exp_word(1'b0, 1'b0, 4'd0, NONE_FIRED, 8'h00, 32'd0));
    add_item(mk_word(OP_WRITE, 8'h00, 5'd31, 4'd15, 4'd0, 8'd7, 1'b0, 3'd0, 1'b1, 8'hAA),
             1'b1, exp_word(1'b0, 1'b0, 4'd0, NONE_FIRED, 8'h00, 32'd0));
    add_cfg(CFG_RULE_COUNT, 16'd4);
    // two priority-zero rules true: the earlier entry wins the tie
    add_item(mk_word(OP_STEP, 8'hFF, 5'd0, 4'd0, 4'd0, 8'd0, 1'b0, 3'd0, 1'b0, 8'h00), 1'b0, '0);
    add_item(mk_word(OP_RESTART, 8'h00, 5'd0, 4'd0, 4'd0, 8'd0, 1'b0, 3'd0, 1'b0, 8'h00), 1'b0, '0);
    // no condition true: falls back on the default rule
    add_item(mk_word(OP_STEP, 8'h00, 5'd0, 4'd0, 4'd0, 8'd0, 1'b0, 3'd0, 1'b0, 8'h00), 1'b0, '0);
    add_item(mk_word(OP_RESTART, 8'h00, 5'd0, 4'd0, 4'd0, 8'd0, 1'b0, 3'd0, 1'b0, 8'h00), 1'b0, '0);
    add_item(mk_word(OP_STEP, 8'h01, 5'd0, 4'd0, 4'd0, 8'd0, 1'b0, 3'd0, 1'b0, 8'h00), 1'b0, '0);
    add_item(mk_word(OP_RESTART, 8'h00, 5'd0, 4'd0, 4'd0, 8'd0, 1'b0, 3'd0, 1'b0, 8'h00), 1'b0, '0);
    add_item(mk_word(OP_STEP, 8'h80, 5'd0, 4'd0, 4'd0, 8'd0, 1'b0, 3'd0, 1'b0, 8'h00), 1'b0, '0);
    add_cfg(CFG_TERMINAL_MASK, 16'hFFFF);
    add_item(mk_word(OP_STEP, 8'h00, 5'd0, 4'd0, 4'd0, 8'd0, 1'b0, 3'd0, 1'b0, 8'h00), 1'b0, '0);
    add_cfg(CFG_START_STATE, 16'd15);
    add_item(mk_word(OP_RESTART, 8'h00, 5'd0, 4'd0, 4'd0, 8'd0, 1'b0, 3'd0, 1'b0, 8'h00),
             1'b1, exp_word(1'b0, 1'b0, 4'd15, NONE_FIRED, 8'h00, 32'd0));
    add_cfg(CFG_TERMINAL_MASK, 16'h8000);
    add_item(mk_word(OP_STEP, 8'hFF, 5'd0, 4'd0, 4'd0, 8'd0, 1'b0, 3'd0, 1'b0, 8'h00),
             1'b1, exp_word(1'b1, 1'b0, 4'd15, NONE_FIRED, 8'h00, 32'd1));
    add_cfg(CFG_TERMINAL_MASK, 16'h0000);
    // entry 31 lies outside the entries in use
    add_item(mk_word(OP_STEP, 8'hFF, 5'd0, 4'd0, 4'd0, 8'd0, 1'b0, 3'd0, 1'b0, 8'h00),
             1'b1, exp_word(1'b0, 1'b1, 4'd15, NONE_FIRED, 8'h00, 32'd2));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        wait_idle();
        reg_write(row.cfg_idx, row.cfg_val);
      end else begin
        send_word(row.word, row.typed, row.want);
      end
    end
    wait_idle();

    per_phase = RANDOM_ITEMS / PHASES;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          tm = 16'h0000; rc = 16'd32; ss = 16'd0; span = 4'hF;
        end
        1: begin
          // counts above the table size act as a full table
          tm = 16'hFFFF; rc = 16'h003F; ss = 16'd15; span = 4'hF;
        end
        2: begin
          tm = 16'h0000; rc = 16'd0; ss = 16'($urandom_range(15)); span = 4'hF;
        end
        default: begin
          span = 4'((1 << $urandom_range(1, 4)) - 1);
          tm = 16'($urandom & $urandom & $urandom);
          rc = 16'($urandom);
          rc[5:0] = ($urandom_range(9) == 0) ? 6'($urandom_range(33, 63))
                                             : 6'($urandom_range(1, 32));
          ss = 16'($urandom);
          ss[3:0] = 4'($urandom_range(15)) & span;
        end
      endcase
      reg_write(CFG_TERMINAL_MASK, tm);
      reg_write(CFG_RULE_COUNT, rc);
      reg_write(CFG_START_STATE, ss);

      no_gaps = (phase == 3) || ($urandom_range(4) == 0);
      pause_at = $urandom_range(per_phase - 1);
      burst_left = 0;
      for (k = 0; k < per_phase; k++) begin
        if (k == pause_at) begin
          wait_idle();
        end else if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = no_gaps ? 0 : $urandom_range(0, 12);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        if (burst_left > 0) burst_left--;
        send_word(random_word(span), 1'b0, '0);
      end
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/prte_pkg.sv
rtl/core/prte_rule_mem.sv
rtl/core/prte_sel.sv
rtl/core/priority_rule_table_fsm_engine_unit.sv
verif/priority_rule_table_fsm_engine_unit_tb.sv
